// ----- design/mexp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for the modular exponentiation block
// Holds the payload width of the channels, the reset modulus and the status
// bundle that the shared modular multiplier reports to the sequencer.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of every payload field and of the configuration register.
  localparam int unsigned FIELD_W = 32;

  // Modulus held in the configuration register after reset.
  localparam logic [FIELD_W-1:0] RESET_MODULUS = 32'd998244353;

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic busy;  // an operation is in progress
    logic done;  // one-cycle pulse, the result is valid
  } mexp_stat_t;

endpackage : mexp_pkg
`default_nettype wire

// ----- design/mexp_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_in_if: request channel of the modular exponentiation block
// Carries one base and one exponent per transaction under valid and ready.
// ----------------------------------------------------------------------------
interface mexp_in_if import mexp_pkg::*;;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);

endinterface : mexp_in_if
`default_nettype wire

// ----- design/mexp_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_out_if: result channel of the modular exponentiation block
// Carries one power result per transaction under valid and ready.
// ----------------------------------------------------------------------------
interface mexp_out_if import mexp_pkg::*;;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);

endinterface : mexp_out_if
`default_nettype wire

// ----- design/modular_exponentiation.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation: base to the exponent modulo a configured modulus
// Right-to-left square and multiply over one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage. A request transaction on in_i carries a base and an exponent; the
// result leaves as one transaction on out_o. The modulus register is written
// through modulus_we_i and modulus_i; the user must write it only while the
// block is idle, which the block does not enforce. A modulus of zero stands
// for 2 to the power OPERAND_BITS.
// Operation. Each modular multiplication occupies the shared multiplier.
// The base is first reduced by one such operation. Then, for each exponent
// bit up to the highest set one, a set bit costs a multiply and every bit
// except the last costs a square, and the sequencer then hands the result
// over. Each clear bit saves a multiply; an exponent of zero still pays for
// the base reduction.
// Throughput. One item at a time; in_i.ready is high only in the idle state.
// Stalls. The result sits in an output register, so a new request is taken
// while the previous result still waits; if the next result is finished
// before then, the sequencer holds it until the output register is free.
// Reset clears the sequencer and the output valid and loads the modulus
// 998244353.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               modulus_we_i,
  input  wire logic [FIELD_W-1:0] modulus_i,
  mexp_in_if.sink                 in_i,
  mexp_out_if.source              out_o
);

  localparam int unsigned N = OPERAND_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a request
  localparam logic [2:0] S_REDUCE = 3'd1;  // base reduced by the modulus
  localparam logic [2:0] S_BIT    = 3'd2;  // inspect the next exponent bit
  localparam logic [2:0] S_MUL    = 3'd3;  // accumulator times power
  localparam logic [2:0] S_SQR    = 3'd4;  // power squared
  localparam logic [2:0] S_FIN    = 3'd5;  // hand the result to the output

  logic [FIELD_W-1:0] modulus_q;
  logic [2:0]         state_q, state_d;
  logic [N-1:0]       exp_q, exp_d;
  logic [N-1:0]       power_q, power_d;
  logic [N-1:0]       acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] out_data_q, out_data_d;

  logic [N-1:0] mod_low;
  logic [N:0]   mod_ext;
  logic         unit_start;
  logic [N-1:0] unit_a;
  logic [N-1:0] unit_b;
  mexp_stat_t   unit_stat;
  logic [N-1:0] unit_result;
  logic         in_fire;
  logic         out_fire;

  // A modulus of zero becomes 2^N through the extra top bit, so that every
  // reduction then keeps the low N bits.
  assign mod_low = modulus_q[N-1:0];
  assign mod_ext = {(mod_low == '0), mod_low};

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= RESET_MODULUS;
    end else if (modulus_we_i) begin
      modulus_q <= modulus_i;
    end
  end

  mexp_mulred #(
    .N(N)
  ) u_mulred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .a_i     (unit_a),
    .b_i     (unit_b),
    .mod_i   (mod_ext),
    .stat_o  (unit_stat),
    .result_o(unit_result)
  );

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    power_d     = power_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    unit_start  = 1'b0;
    unit_a      = power_q;
    unit_b      = power_q;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // The base is reduced as 1 * base, which the unit allows for any
          // modulus, a modulus of one included.
          unit_start = 1'b1;
          unit_a     = N'(1);
          unit_b     = in_i.base[N-1:0];
          exp_d      = in_i.exponent[N-1:0];
          acc_d      = (mod_ext == (N+1)'(1)) ? '0 : N'(1);
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (unit_stat.done) begin
          power_d = unit_result;
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (exp_q == '0) begin
          state_d = S_FIN;
        end else if (exp_q[0]) begin
          unit_start = 1'b1;
          unit_a     = acc_q;
          state_d    = S_MUL;
        end else begin
          unit_start = 1'b1;
          state_d    = S_SQR;
        end
      end
      S_MUL: begin
        if (unit_stat.done) begin
          acc_d = unit_result;
          // No higher bit set: the last square would go unused.
          if (exp_q[N-1:1] == '0) begin
            state_d = S_FIN;
          end else begin
            unit_start = 1'b1;
            state_d    = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (unit_stat.done) begin
          power_d = unit_result;
          exp_d   = {1'b0, exp_q[N-1:1]};
          state_d = S_BIT;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = FIELD_W'(acc_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q      <= exp_d;
    power_q    <= power_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.power_result = out_data_q;

  // The multiplier only reports completion while the sequencer waits for it.
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_stat.done |-> (state_q == S_REDUCE || state_q == S_MUL || state_q == S_SQR))
    else $error("multiplier finished outside a waiting state");

  // A new operation is never launched over one in progress.
  a_no_start_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_start |-> !unit_stat.busy)
    else $error("multiplier started while busy");

  // An accepted request starts the base reduction at once.
  a_request_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_REDUCE && unit_stat.busy))
    else $error("request did not start the base reduction");

  // A result appears only when the sequencer hands it over.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("output valid raised outside the hand-over state");

endmodule : modular_exponentiation
`default_nettype wire

// ----- design/mexp_mulred.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_mulred: bit-serial modular multiplier
// Computes a * b mod m by interleaved shift, add and reduce, one multiplier
// bit per cycle, most significant bit first. Needs a <= m; m is given with
// one extra bit so that 2^N stands for a modulus of zero.
// ----------------------------------------------------------------------------
module mexp_mulred import mexp_pkg::*; #(
  parameter int unsigned N = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] a_i,
  input  wire logic [N-1:0] b_i,
  input  wire logic [N:0]   mod_i,
  output mexp_stat_t        stat_o,
  output logic      [N-1:0] result_o
);

  localparam int unsigned CntW = $clog2(N);

  logic            running_q, running_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [N-1:0]    a_q, a_d;
  logic [N-1:0]    b_q, b_d;
  logic [N-1:0]    r_q, r_d;

  logic [N:0] dbl;
  logic [N:0] dbl_red;
  logic [N:0] sum;
  logic [N:0] sum_red;

  // Double the partial remainder and bring it back below m, then add the
  // multiplicand when the current multiplier bit is set and reduce again.
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= mod_i) ? dbl - mod_i : dbl;
    sum     = {1'b0, dbl_red[N-1:0]} + {1'b0, (b_q[N-1] ? a_q : '0)};
    sum_red = (sum >= mod_i) ? sum - mod_i : sum;
  end

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    a_d       = a_q;
    b_d       = b_q;
    r_d       = r_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = CntW'(N - 1);
      a_d       = a_i;
      b_d       = b_i;
      r_d       = '0;
    end else if (running_q) begin
      r_d   = sum_red[N-1:0];
      b_d   = {b_q[N-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign stat_o.busy = running_q;
  assign stat_o.done = done_q;
  assign result_o    = r_q;

endmodule : mexp_mulred
`default_nettype wire

// ----- dv/mexp_power_checker.sv -----
// ----------------------------------------------------------------------------
// mexp_power_checker: result checker for the modular exponentiation block
// Watches both channels and the modulus write port. It works out base to the
// exponent modulo the current modulus for every accepted request, and checks
// every result transaction against the oldest outstanding value.
// ----------------------------------------------------------------------------
module mexp_power_checker import mexp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic               modulus_we_i,
  input  logic [FIELD_W-1:0] modulus_i,
  mexp_in_if                 req_i,
  mexp_out_if                rsp_i,
  output int                 error_count_o,
  output int                 pending_o
);

  localparam int unsigned WIDE_W = 2 * FIELD_W;

  typedef struct {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] power_result;
  } power_entry_t;

  power_entry_t       awaited_powers[$];
  power_entry_t       entry;
  power_entry_t       oldest;
  logic [FIELD_W-1:0] modulus_copy;
  int                 errors = 0;

  assign error_count_o = errors;

  // A modulus of zero stands for 2 to the power of the field width, so the
  // value simply wraps to its low bits.
  function automatic logic [FIELD_W-1:0] reduce_mod(input logic [WIDE_W-1:0] v,
                                                     input logic [FIELD_W-1:0] m);
    logic [WIDE_W-1:0] r;
    if (m == '0) return v[FIELD_W-1:0];
    r = v % {{FIELD_W{1'b0}}, m};
    return r[FIELD_W-1:0];
  endfunction

  // Right-to-left square and multiply with exact double-width products.
  function automatic logic [FIELD_W-1:0] mod_power_of(input logic [FIELD_W-1:0] b,
                                                      input logic [FIELD_W-1:0] e,
                                                      input logic [FIELD_W-1:0] m);
    logic [FIELD_W-1:0] sq;
    logic [FIELD_W-1:0] acc;
    sq  = reduce_mod({{FIELD_W{1'b0}}, b}, m);
    acc = reduce_mod({{(WIDE_W-1){1'b0}}, 1'b1}, m);
    for (int i = 0; i < FIELD_W; i++) begin
      if (e[i]) acc = reduce_mod({{FIELD_W{1'b0}}, acc} * {{FIELD_W{1'b0}}, sq}, m);
      sq = reduce_mod({{FIELD_W{1'b0}}, sq} * {{FIELD_W{1'b0}}, sq}, m);
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_copy = RESET_MODULUS;
      awaited_powers.delete();
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_powers.size() == 0) begin
          $error("power_result 0x%08h arrived with no request outstanding",
                 rsp_i.power_result);
          errors++;
        end else begin
          oldest = awaited_powers.pop_front();
          if (rsp_i.power_result !== oldest.power_result) begin
            $error("power_result mismatch: expected 0x%08h, actual 0x%08h (base 0x%08h, exponent 0x%08h, modulus 0x%08h)",
                   oldest.power_result, rsp_i.power_result, oldest.base,
                   oldest.exponent, oldest.modulus);
            errors++;
          end
        end
      end
      // The modulus register only changes while the block is idle, so the
      // copy held here is the one a request accepted now will use.
      if (req_i.valid && req_i.ready) begin
        entry.base         = req_i.base;
        entry.exponent     = req_i.exponent;
        entry.modulus      = modulus_copy;
        entry.power_result = mod_power_of(req_i.base, req_i.exponent, modulus_copy);
        awaited_powers.push_back(entry);
      end
      if (modulus_we_i) modulus_copy = modulus_i;
      pending_o <= awaited_powers.size();
    end
  end

endmodule : mexp_power_checker

// ----- dv/modular_exponentiation_tb.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_tb: top level of the modular exponentiation bench
// Drives requests and modulus writes into the block, throttles the result
// channel at random and leaves all checking to the power checker beside it.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned PRESSURE_PHASE  = 3;
  // Length of the long result hold-off. It is well above the latency of a
  // short exponent, so the output register and the sequencer both fill up
  // and the request channel has to stall.
  localparam int unsigned HOLD_CYCLES     = 4000;
  // Even if every one of the roughly 1820 requests took as long as one with a
  // full exponent and met the longest gaps on both sides, the run would stay
  // well below this limit.
  localparam int unsigned CYCLE_LIMIT     = 20_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               modulus_we  = 1'b0;
  logic [FIELD_W-1:0] modulus_val = '0;

  mexp_in_if  req_ch ();
  mexp_out_if rsp_ch ();

  int          error_count;
  int          pending;
  int unsigned requests_sent = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count   = 0;
  // Set in the closing phase: from then on neither side idles.
  bit          no_idle  = 1'b0;
  // Raised by the stimulus to ask the result side for one long hold-off.
  bit          hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  modular_exponentiation DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .modulus_we_i (modulus_we),
    .modulus_i    (modulus_val),
    .in_i         (req_ch),
    .out_o        (rsp_ch)
  );

  mexp_power_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .modulus_we_i  (modulus_we),
    .modulus_i     (modulus_val),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // Offers one request and returns at the edge at which it is accepted. Now
  // and then a short gap goes first, so that gaps fall at every point of the
  // block's work. The valid is lowered only when a gap follows, never lowered
  // and raised again at the same edge.
  task automatic send_request(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.base     <= b;
    req_ch.exponent <= e;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
  endtask

  // Stops offering and waits until every outstanding result transaction has
  // come back. The first edge lets the checker's count catch up with the
  // request that was accepted last. Every request yields a result, so once
  // the count is zero the block is idle; a few spare cycles follow anyway.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Modulus writes happen only once the block has gone idle.
  task automatic write_modulus(input logic [FIELD_W-1:0] m);
    drain_results();
    modulus_we  <= 1'b1;
    modulus_val <= m;
    @(posedge clk);
    modulus_we  <= 1'b0;
    settings_used++;
  endtask

  // An exponent whose highest set bit is at position len-1. The block's time
  // grows with that position, so it is the knob that keeps the run short.
  function automatic logic [FIELD_W-1:0] exponent_of_length(input int unsigned len);
    logic [63:0] r;
    if (len == 0) return '0;
    r = {$urandom, $urandom};
    r = r & ((64'd1 << len) - 64'd1);
    r[len-1] = 1'b1;
    return r[FIELD_W-1:0];
  endfunction

  // Mostly short exponents, a fair share of medium ones and a few with all
  // bits random; the last kind sets every high exponent bit both ways.
  function automatic logic [FIELD_W-1:0] random_exponent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return exponent_of_length($urandom_range(0, 6));
    if (pick < 92) return exponent_of_length($urandom_range(7, 14));
    return $urandom;
  endfunction

  // Bases close to the modulus and at the ends of the range turn up often,
  // since they exercise the initial reduction of the base.
  function automatic logic [FIELD_W-1:0] random_base(input logic [FIELD_W-1:0] m);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 1;
      2:       return m - 1;
      3:       return m;
      4:       return m + 1;
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Cycle limit: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("modular_exponentiation_tb: FAIL");
      $finish;
    end
  end

  // Result side. Ready runs alternate with short stalls; once the stimulus
  // asks for it, a single long hold-off is counted out here while the request
  // side carries on offering. In the closing phase the result side is always
  // ready.
  initial begin : result_side
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin : request_side
    logic [FIELD_W-1:0] m;
    req_ch.valid    <= 1'b0;
    req_ch.base     <= '0;
    req_ch.exponent <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. First the reset modulus: zero operands, exponent zero,
    // and the widest base and exponent.
    send_request('0, '0);
    send_request('0, 1);
    send_request(1, '1);
    send_request('1, '1);
    send_request(RESET_MODULUS, 5);
    send_request(2, 32'h8000_0000);

    // Modulus one: everything reduces to zero, exponent zero included.
    write_modulus(1);
    send_request(5, '0);
    send_request('1, '1);
    send_request('0, 3);

    // Modulus zero stands for the full 2 to the power 32, so products wrap.
    write_modulus('0);
    send_request(3, '0);
    send_request(2, 31);
    send_request(2, 32);
    send_request('1, '1);
    send_request('0, '0);
    send_request(32'h1234_5679, 32'h0000_FFFF);

    // The largest modulus, with bases at and around it.
    write_modulus('1);
    send_request(32'hFFFF_FFFE, 2);
    send_request('1, 5);
    send_request('1, '0);
    send_request('0, '1);

    // The smallest ordinary modulus.
    write_modulus(2);
    send_request(3, 1);
    send_request(2, 5);
    send_request('1, '1);
    send_request(4, '0);

    // Random part: one modulus setting per phase, the block drained before
    // every write.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0:       m = '1;
        1:       m = '0;
        2:       m = 2;
        3:       m = RESET_MODULUS;
        4:       m = 1;
        5:       m = $urandom_range(3, 255);
        6:       m = 32'hFFFF_FFFB;
        7:       m = $urandom;
        8:       m = 65537;
        9:       m = $urandom | 32'h8000_0000;
        10:      m = $urandom_range(2, 65535);
        default: m = $urandom;
      endcase
      write_modulus(m);
      if (p == PHASES - 1) no_idle = 1'b1;
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // While the result side holds off, short exponents make the block
        // finish quickly and then back up against its own output.
        if (p == PRESSURE_PHASE && n < 8)
          send_request(random_base(m), exponent_of_length($urandom_range(0, 6)));
        else
          send_request(random_base(m), random_exponent());
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Checked %0d requests over %0d modulus settings, moduli 0, 1, 2 and 2^32-1 among them.",
             requests_sent, settings_used);
    $display("Random stalls on both channels, one %0d-cycle result hold-off, stall-free closing phase.",
             HOLD_CYCLES);
    if (error_count == 0 && pending == 0) begin
      $display("modular_exponentiation_tb: PASS");
    end else begin
      $display("modular_exponentiation_tb: FAIL");
    end
    $finish;
  end

endmodule : modular_exponentiation_tb
